[design/tqpt_pkg.sv]
`timescale 1ns / 1ps
package tqpt_pkg;

   // event codes on the result channel
   localparam logic [1:0] EV_MAIN_HIT  = 2'd0;
   localparam logic [1:0] EV_PROB_HIT  = 2'd1;
   localparam logic [1:0] EV_DEMOTE    = 2'd2;
   localparam logic [1:0] EV_PROMOTE   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [1:0] CSR_IN_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_OUT_LIMIT = 2'd2;

   localparam int CSR_DATA_BITS = 9;

   localparam logic [8:0] CAPACITY_RESET  = 9'd256;
   localparam logic [7:0] IN_LIMIT_RESET  = 8'd64;
   localparam logic [7:0] OUT_LIMIT_RESET = 8'd128;

   // command broadcast to every resident slot cell
   typedef struct packed {
      logic refresh;      // main hit: move matching page to front
      logic insert;       // place the page at the front of a list
      logic insert_main;  // 1 main list, 0 probation list
      logic full;         // set is full, insert goes into the victim slot
      logic evict_main;   // victim is the main tail
      logic evict_prob;   // victim is the probation tail
   } slot_cmd_type;

   // command broadcast to every history cell
   typedef struct packed {
      logic clear_hit;    // kill a live matching entry
      logic drop_first;   // drop oldest before push (storage full)
      logic write;        // push victim page
      logic drop_second;  // drop oldest after push (over out_limit)
   } hist_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOOK = 4'b0010,
      S_ACT  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

endpackage

[design/tqpt_slot_cell.sv]
`timescale 1ns / 1ps
module tqpt_slot_cell #(
   parameter int CELL_INDEX = 0,
   parameter int PAGE_BITS  = 36,
   parameter int AGE_BITS   = 8,
   parameter int CNT_BITS   = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [PAGE_BITS-1:0]     page_q,
   input  tqpt_pkg::slot_cmd_type   cmd,
   input  logic [AGE_BITS-1:0]      hit_age,
   input  logic [AGE_BITS-1:0]      main_tail_age,
   input  logic [AGE_BITS-1:0]      prob_tail_age,
   input  logic [CNT_BITS-1:0]      fill_index,
   output logic                     match_main,
   output logic                     match_prob,
   output logic                     tail_main,
   output logic                     tail_prob,
   output logic [AGE_BITS-1:0]      age,
   output logic [PAGE_BITS-1:0]     page
);
   import tqpt_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 main_ff, main_in;
   logic [AGE_BITS-1:0]  age_ff, age_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 match;
   logic                 evict_here;
   logic                 insert_here;

   assign match      = valid_ff && (page_ff == page_q);
   assign match_main = match && main_ff;
   assign match_prob = match && !main_ff;
   assign tail_main  = valid_ff && main_ff && (age_ff == main_tail_age);
   assign tail_prob  = valid_ff && !main_ff && (age_ff == prob_tail_age);
   assign age        = age_ff;
   assign page       = page_ff;

   assign evict_here  = (cmd.evict_main && tail_main) || (cmd.evict_prob && tail_prob);
   assign insert_here = cmd.full ? evict_here
                                 : (fill_index == CNT_BITS'(CELL_INDEX));

   always_comb begin
      valid_in = valid_ff;
      main_in  = main_ff;
      age_in   = age_ff;
      page_in  = page_ff;
      if (cmd.refresh) begin
         if (match_main) begin
            age_in = '0;
         end else if (valid_ff && main_ff && (age_ff < hit_age)) begin
            age_in = age_ff + 1'b1;
         end
      end else if (cmd.insert) begin
         if (insert_here) begin
            valid_in = 1'b1;
            main_in  = cmd.insert_main;
            age_in   = '0;
            page_in  = page_q;
         end else if (valid_ff && (main_ff == cmd.insert_main)) begin
            age_in = age_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         main_ff  <= 1'b0;
         age_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         main_ff  <= main_in;
         age_ff   <= age_in;
      end
      page_ff <= page_in;
   end

endmodule

[design/tqpt_hist_cell.sv]
`timescale 1ns / 1ps
module tqpt_hist_cell #(
   parameter int CELL_INDEX = 0,
   parameter int PAGE_BITS  = 36,
   parameter int IDX_BITS   = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [PAGE_BITS-1:0]   page_q,
   input  logic [PAGE_BITS-1:0]   push_page,
   input  tqpt_pkg::hist_cmd_type cmd,
   input  logic [IDX_BITS-1:0]    first_idx,
   input  logic [IDX_BITS-1:0]    write_idx,
   input  logic [IDX_BITS-1:0]    second_idx,
   output logic                   match
);
   import tqpt_pkg::*;

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

   logic                 live_ff, live_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;

   assign match = live_ff && (page_ff == page_q);

   // later operations of the same beat win
   always_comb begin
      live_in = live_ff;
      page_in = page_ff;
      if ((cmd.clear_hit && match) || (cmd.drop_first && first_idx == MY_IDX)) begin
         live_in = 1'b0;
      end
      if (cmd.write && write_idx == MY_IDX) begin
         live_in = 1'b1;
         page_in = push_page;
      end
      if (cmd.drop_second && second_idx == MY_IDX) begin
         live_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
      end
      page_ff <= page_in;
   end

endmodule

[design/two_queue_page_tier_policy_unit.sv]
`timescale 1ns / 1ps
// 2q fast-tier page placement policy
// req channel: one sampled page number per beat (req_valid / req_stall)
// rsp channel: event beats (event, page, last); a main or probation hit gives
//   one beat, a new or history page gives an optional demote then a promote,
//   and last marks the final beat of an access
// csr port: write-only, index 0 capacity, 1 in_limit, 2 out_limit; write only
//   while the block is idle
// a request passes the compare, decide/update and output register stages
//   before its first response beat; a second beat follows on the cycle
//   after the first is taken
// throughput: one access at a time, also when the receiver never stalls
//   and when a demote precedes the promote; the compare row and the
//   single update pass set it
// the resident set is a row of slot cells, each comparing its page with the
//   request and updating its own age; the history fifo is a row of cells too
// reset clears all valid/live bits, counters and csr values at once; no
//   clearing sweep is needed
// a stalled response holds its beat and the block takes no new request
//   until every beat of the current access has been taken
module two_queue_page_tier_policy_unit #(
   parameter int RESIDENT_SLOTS   = 256,
   parameter int HISTORY_SLOTS    = 128,
   parameter int PAGE_NUMBER_BITS = 36
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [PAGE_NUMBER_BITS-1:0] req_page_number,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_event_res,
   output logic [PAGE_NUMBER_BITS-1:0] rsp_page_id,
   output logic                        rsp_last,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [tqpt_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import tqpt_pkg::*;

   localparam int AGE_BITS  = $clog2(RESIDENT_SLOTS);
   localparam int CNT_BITS  = $clog2(RESIDENT_SLOTS + 1);
   localparam int HIDX_BITS = $clog2(HISTORY_SLOTS);
   localparam int HCNT_BITS = $clog2(HISTORY_SLOTS + 1);
   localparam int CMP_BITS  = (CNT_BITS > 9 ? CNT_BITS : 9) + 1;
   localparam int HCMP_BITS = (HCNT_BITS > 8 ? HCNT_BITS : 8) + 1;
   localparam int PB        = PAGE_NUMBER_BITS;

   // csr registers
   logic [8:0] capacity_ff;
   logic [7:0] in_limit_ff;
   logic [7:0] out_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         in_limit_ff  <= IN_LIMIT_RESET;
         out_limit_ff <= OUT_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CAPACITY:  capacity_ff  <= csr_data;
            CSR_IN_LIMIT:  in_limit_ff  <= csr_data[7:0];
            CSR_OUT_LIMIT: out_limit_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // control and list state
   state_type             state_ff, state_in;
   logic [PB-1:0]         page_ff;
   logic [CNT_BITS-1:0]   main_cnt_ff, main_cnt_in;
   logic [CNT_BITS-1:0]   prob_cnt_ff, prob_cnt_in;
   logic [HIDX_BITS-1:0]  hhead_ff, hhead_in;
   logic [HCNT_BITS-1:0]  hcnt_ff, hcnt_in;

   // compare results captured in the look cycle
   logic                  main_hit_ff, prob_hit_ff, hist_hit_ff;
   logic [AGE_BITS-1:0]   hit_age_ff;
   logic [PB-1:0]         main_tail_page_ff, prob_tail_page_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_event_ff, rsp_event_in;
   logic [PB-1:0]         rsp_page_ff, rsp_page_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  pend_ff, pend_in;

   // cell row wiring
   logic [RESIDENT_SLOTS-1:0] c_match_main, c_match_prob, c_tail_main, c_tail_prob;
   logic [AGE_BITS-1:0]       c_age  [RESIDENT_SLOTS];
   logic [PB-1:0]             c_page [RESIDENT_SLOTS];
   logic [HISTORY_SLOTS-1:0]  h_match;

   slot_cmd_type          scmd;
   hist_cmd_type          hcmd;
   logic [AGE_BITS-1:0]   main_tail_age, prob_tail_age;
   logic [CNT_BITS-1:0]   occupancy;
   logic [HIDX_BITS-1:0]  first_idx, write_idx, second_idx;
   logic [PB-1:0]         victim_page;

   assign main_tail_age = AGE_BITS'(main_cnt_ff - 1'b1);
   assign prob_tail_age = AGE_BITS'(prob_cnt_ff - 1'b1);
   assign occupancy     = main_cnt_ff + prob_cnt_ff;

   for (genvar g = 0; g < RESIDENT_SLOTS; g++) begin : g_slot
      tqpt_slot_cell #(
         .CELL_INDEX (g),
         .PAGE_BITS  (PB),
         .AGE_BITS   (AGE_BITS),
         .CNT_BITS   (CNT_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .page_q        (page_ff),
         .cmd           (scmd),
         .hit_age       (hit_age_ff),
         .main_tail_age (main_tail_age),
         .prob_tail_age (prob_tail_age),
         .fill_index    (occupancy),
         .match_main    (c_match_main[g]),
         .match_prob    (c_match_prob[g]),
         .tail_main     (c_tail_main[g]),
         .tail_prob     (c_tail_prob[g]),
         .age           (c_age[g]),
         .page          (c_page[g])
      );
   end

   for (genvar g = 0; g < HISTORY_SLOTS; g++) begin : g_hist
      tqpt_hist_cell #(
         .CELL_INDEX (g),
         .PAGE_BITS  (PB),
         .IDX_BITS   (HIDX_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .page_q     (page_ff),
         .push_page  (prob_tail_page_ff),
         .cmd        (hcmd),
         .first_idx  (first_idx),
         .write_idx  (write_idx),
         .second_idx (second_idx),
         .match      (h_match[g])
      );
   end

   // or-mux of the one selected cell per field
   logic [AGE_BITS-1:0] hit_age_sel;
   logic [PB-1:0]       main_tail_sel, prob_tail_sel;

   always_comb begin
      hit_age_sel   = '0;
      main_tail_sel = '0;
      prob_tail_sel = '0;
      for (int i = 0; i < RESIDENT_SLOTS; i++) begin
         hit_age_sel   = hit_age_sel   | (c_match_main[i] ? c_age[i]  : '0);
         main_tail_sel = main_tail_sel | (c_tail_main[i]  ? c_page[i] : '0);
         prob_tail_sel = prob_tail_sel | (c_tail_prob[i]  ? c_page[i] : '0);
      end
   end

   // decision: free a slot when the set is full
   logic [CMP_BITS-1:0] cap_eff;
   logic                full;
   logic                victim_prob;

   always_comb begin
      if (capacity_ff == 9'd0) begin
         cap_eff = CMP_BITS'(1);
      end else if (CMP_BITS'(capacity_ff) > CMP_BITS'(RESIDENT_SLOTS)) begin
         cap_eff = CMP_BITS'(RESIDENT_SLOTS);
      end else begin
         cap_eff = CMP_BITS'(capacity_ff);
      end
   end

   assign full        = CMP_BITS'(occupancy) >= cap_eff;
   assign victim_prob = (CMP_BITS'(prob_cnt_ff) > CMP_BITS'(in_limit_ff))
                        || (main_cnt_ff == '0);
   assign victim_page = victim_prob ? prob_tail_page_ff : main_tail_page_ff;

   // history push arithmetic
   logic                 push;
   logic                 drop1, drop2;
   logic [HIDX_BITS-1:0] head1;
   logic [HCNT_BITS-1:0] cnt1, cnt2;
   logic [HCNT_BITS:0]   pos_sum;

   function automatic logic [HIDX_BITS-1:0] next_idx(input logic [HIDX_BITS-1:0] v);
      logic [HIDX_BITS-1:0] r;
      if (HCNT_BITS'(v) + 1'b1 >= HCNT_BITS'(HISTORY_SLOTS)) begin
         r = '0;
      end else begin
         r = v + 1'b1;
      end
      return r;
   endfunction

   assign push  = state_ff == S_ACT && !main_hit_ff && (hist_hit_ff || !prob_hit_ff)
                  && full && victim_prob;
   assign drop1 = hcnt_ff >= HCNT_BITS'(HISTORY_SLOTS);
   assign head1 = drop1 ? next_idx(hhead_ff) : hhead_ff;
   assign cnt1  = drop1 ? hcnt_ff - 1'b1 : hcnt_ff;
   assign pos_sum = (HCNT_BITS+1)'(head1) + (HCNT_BITS+1)'(cnt1);
   assign write_idx = (pos_sum >= (HCNT_BITS+1)'(HISTORY_SLOTS))
                      ? HIDX_BITS'(pos_sum - (HCNT_BITS+1)'(HISTORY_SLOTS))
                      : HIDX_BITS'(pos_sum);
   assign cnt2  = cnt1 + 1'b1;
   assign drop2 = HCMP_BITS'(cnt2) > HCMP_BITS'(out_limit_ff);
   assign first_idx  = hhead_ff;
   assign second_idx = head1;

   // sequencer
   logic do_insert;
   assign do_insert = state_ff == S_ACT && !main_hit_ff && (hist_hit_ff || !prob_hit_ff);

   always_comb begin
      state_in     = state_ff;
      main_cnt_in  = main_cnt_ff;
      prob_cnt_in  = prob_cnt_ff;
      hhead_in     = hhead_ff;
      hcnt_in      = hcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_event_in = rsp_event_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_last_in  = rsp_last_ff;
      pend_in      = pend_ff;
      scmd         = '0;
      hcmd         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_ACT;
         end
         S_ACT: begin
            state_in     = S_OUT;
            rsp_valid_in = 1'b1;
            rsp_page_in  = page_ff;
            rsp_last_in  = 1'b1;
            pend_in      = 1'b0;
            if (main_hit_ff) begin
               scmd.refresh = 1'b1;
               rsp_event_in = EV_MAIN_HIT;
            end else if (!hist_hit_ff && prob_hit_ff) begin
               rsp_event_in = EV_PROB_HIT;
            end else begin
               hcmd.clear_hit   = 1'b1;
               scmd.insert      = 1'b1;
               scmd.insert_main = hist_hit_ff;
               scmd.full        = full;
               rsp_event_in     = EV_PROMOTE;
               if (full) begin
                  scmd.evict_main = !victim_prob;
                  scmd.evict_prob = victim_prob;
                  rsp_event_in    = EV_DEMOTE;
                  rsp_page_in     = victim_page;
                  rsp_last_in     = 1'b0;
                  pend_in         = 1'b1;
               end
               // net count change after eviction and insertion
               if (hist_hit_ff) begin
                  main_cnt_in = main_cnt_ff + 1'b1;
               end else begin
                  prob_cnt_in = prob_cnt_ff + 1'b1;
               end
               if (full) begin
                  if (victim_prob) begin
                     prob_cnt_in = prob_cnt_in - 1'b1;
                  end else begin
                     main_cnt_in = main_cnt_in - 1'b1;
                  end
               end
               if (push) begin
                  hcmd.drop_first  = drop1;
                  hcmd.write       = 1'b1;
                  hcmd.drop_second = drop2;
                  hhead_in = drop2 ? next_idx(head1) : head1;
                  hcnt_in  = drop2 ? cnt1 : cnt2;
               end
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (pend_ff) begin
                  pend_in      = 1'b0;
                  rsp_event_in = EV_PROMOTE;
                  rsp_page_in  = page_ff;
                  rsp_last_in  = 1'b1;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         main_cnt_ff  <= '0;
         prob_cnt_ff  <= '0;
         hhead_ff     <= '0;
         hcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         main_cnt_ff  <= main_cnt_in;
         prob_cnt_ff  <= prob_cnt_in;
         hhead_ff     <= hhead_in;
         hcnt_ff      <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      rsp_event_ff <= rsp_event_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_last_ff  <= rsp_last_in;
      if (state_ff == S_IDLE && req_valid) begin
         page_ff <= req_page_number;
      end
      if (state_ff == S_LOOK) begin
         main_hit_ff       <= |c_match_main;
         prob_hit_ff       <= |c_match_prob;
         hist_hit_ff       <= |h_match;
         hit_age_ff        <= hit_age_sel;
         main_tail_page_ff <= main_tail_sel;
         prob_tail_page_ff <= prob_tail_sel;
      end
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_page_id   = rsp_page_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
   import tqpt_pkg::*;

   localparam int SLOTS     = 256;
   localparam int HIST      = 128;
   localparam int PB        = 36;
   localparam int IDLE_MAX  = 4000;   // cycles with no beat on either side

   typedef struct {
      logic [1:0]    ev;
      logic [PB-1:0] page;
      logic          last;
   } tier_event_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [PB-1:0] req_page_number = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [1:0]    rsp_event_res;
   logic [PB-1:0] rsp_page_id;
   logic          rsp_last;
   logic          csr_write_enable = 1'b0;
   logic [1:0]    csr_index = CSR_CAPACITY;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   two_queue_page_tier_policy_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_page_number(req_page_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_event_res(rsp_event_res),
      .rsp_page_id(rsp_page_id), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- tier model: own copy of the 2q state ----------------
   logic [PB-1:0] res_page [SLOTS];
   bit            res_valid [SLOTS];
   bit            res_main [SLOTS];
   int            res_age [SLOTS];
   int            main_cnt, prob_cnt;
   logic [PB-1:0] ghost_page [HIST];
   bit            ghost_live [HIST];
   int            ghost_head, ghost_cnt;
   int            cfg_capacity, cfg_in_limit, cfg_out_limit;

   tier_event_type expected_events [$];
   int            errors = 0;
   bit            quiet = 1'b0;   // no idling on either side while set

   function automatic int list_tail(bit in_main);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (res_valid[i] && res_main[i] == in_main &&
             (best < 0 || res_age[i] > res_age[best]))
            best = i;
      return best;
   endfunction

   function automatic void expect_event(logic [1:0] ev, logic [PB-1:0] pg, logic last);
      tier_event_type e;
      e.ev = ev;
      e.page = pg;
      e.last = last;
      expected_events.push_back(e);
   endfunction

   function automatic void ghost_drop_oldest();
      if (ghost_cnt == 0)
         return;
      ghost_live[ghost_head] = 0;
      ghost_head = (ghost_head + 1 >= HIST) ? 0 : ghost_head + 1;
      ghost_cnt--;
   endfunction

   function automatic void ghost_push(logic [PB-1:0] pg);
      int pos;
      // storage full drops the oldest first, whatever out_limit says
      if (ghost_cnt >= HIST)
         ghost_drop_oldest();
      pos = ghost_head + ghost_cnt;
      if (pos >= HIST)
         pos -= HIST;
      ghost_page[pos] = pg;
      ghost_live[pos] = 1;
      ghost_cnt++;
      if (ghost_cnt > cfg_out_limit)
         ghost_drop_oldest();
   endfunction

   // works out the beats one access causes and updates the tier state
   function automatic void predict_access(logic [PB-1:0] pg);
      int hit_main, hit_ghost, hit_prob, t, cap, free_idx;
      bit to_main;
      hit_main = -1;
      hit_ghost = -1;
      hit_prob = -1;
      free_idx = -1;
      for (int i = 0; i < SLOTS; i++)
         if (res_valid[i] && res_page[i] == pg) begin
            if (res_main[i]) hit_main = i;
            else hit_prob = i;
         end
      // main hit: refresh recency
      if (hit_main >= 0) begin
         for (int i = 0; i < SLOTS; i++)
            if (res_valid[i] && res_main[i] && res_age[i] < res_age[hit_main])
               res_age[i]++;
         res_age[hit_main] = 0;
         expect_event(EV_MAIN_HIT, pg, 1'b1);
         return;
      end
      for (int i = 0; i < HIST; i++)
         if (hit_ghost < 0 && ghost_live[i] && ghost_page[i] == pg)
            hit_ghost = i;
      if (hit_ghost < 0 && hit_prob >= 0) begin
         expect_event(EV_PROB_HIT, pg, 1'b1);
         return;
      end
      // history hit kills the entry in place
      if (hit_ghost >= 0)
         ghost_live[hit_ghost] = 0;
      // free a slot when the set is full; capacity clamps to 1..SLOTS
      cap = (cfg_capacity < 1) ? 1 : (cfg_capacity > SLOTS) ? SLOTS : cfg_capacity;
      if (main_cnt + prob_cnt >= cap) begin
         if (prob_cnt > cfg_in_limit || main_cnt == 0) begin
            t = list_tail(1'b0);
            if (t >= 0) begin
               res_valid[t] = 0;
               prob_cnt--;
               expect_event(EV_DEMOTE, res_page[t], 1'b0);
               ghost_push(res_page[t]);
            end
         end else begin
            t = list_tail(1'b1);
            if (t >= 0) begin
               res_valid[t] = 0;
               main_cnt--;
               expect_event(EV_DEMOTE, res_page[t], 1'b0);
            end
         end
      end
      // insert at the front: history hits go to main, new pages to probation
      to_main = (hit_ghost >= 0);
      for (int i = 0; i < SLOTS; i++) begin
         if (!res_valid[i]) begin
            if (free_idx < 0) free_idx = i;
         end else if (res_main[i] == to_main) begin
            res_age[i]++;
         end
      end
      if (free_idx >= 0) begin
         res_page[free_idx] = pg;
         res_valid[free_idx] = 1;
         res_main[free_idx] = to_main;
         res_age[free_idx] = 0;
         if (to_main) main_cnt++;
         else prob_cnt++;
      end
      expect_event(EV_PROMOTE, pg, 1'b1);
   endfunction

   // ---------------- response side: stall and compare ----------------
   int rsp_wait = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("unexpected beat: event %0d page %h", rsp_event_res, rsp_page_id);
               errors++;
            end else begin
               tier_event_type e;
               e = expected_events.pop_front();
               if (rsp_event_res !== e.ev) begin
                  $error("event_res exp %0d got %0d", e.ev, rsp_event_res);
                  errors++;
               end
               if (rsp_page_id !== e.page) begin
                  $error("page_id exp %h got %h", e.page, rsp_page_id);
                  errors++;
               end
               if (rsp_last !== e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_last);
                  errors++;
               end
            end
            // new stall budget for the next beat
            rsp_wait = quiet ? 0 : $urandom_range(0, 17);
         end
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: too long with no beat on either channel
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("** two_queue_page_tier_policy_unit: FAILED **");
         $finish;
      end
   end

   // ---------------- request side ----------------
   // one access beat; valid stays high across back-to-back beats
   task automatic send_page(input logic [PB-1:0] pg);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_page_number <= pg;
      do @(posedge clock); while (req_stall);
      predict_access(pg);
   endtask

   // lower valid, wait for every expected beat, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // writes all three registers while the block is idle
   task automatic set_policy(input int cap, input int in_lim, input int out_lim);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CAPACITY;
      csr_data <= cap[8:0];
      @(posedge clock);
      csr_index <= CSR_IN_LIMIT;
      csr_data <= {1'b0, in_lim[7:0]};
      @(posedge clock);
      csr_index <= CSR_OUT_LIMIT;
      csr_data <= {1'b0, out_lim[7:0]};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_capacity = cap & 'h1FF;
      cfg_in_limit = in_lim & 'hFF;
      cfg_out_limit = out_lim & 'hFF;
   endtask

   // extremes of the page field plus each outcome under a two-slot set
   task automatic test_corner_pages();
      logic [PB-1:0] pa, pb, pc, pd;
      pa = '0;
      pb = '1;
      pc = 36'h5_A5A5_A5A5;
      pd = 36'hA_5A5A_5A5A;
      send_page(pa);          // new page under reset policy
      send_page(pb);
      send_page(pa);          // probation hit
      set_policy(2, 0, 1);
      send_page(pc);          // full set: probation tail to history
      send_page(pa);          // history hit -> main, probation victim
      send_page(pa);          // main hit
      send_page(pd);
      send_page(pb);
      set_policy(2, 255, 1);
      send_page(pc);          // in_limit high: main tail goes
      send_page(pd);
      send_page(pd);
      set_policy(0, 0, 0);    // zero capacity acts as one slot
      send_page(pa);
      send_page(pb);
      send_page(pa);
      send_page(pb);
      set_policy(511, 255, 255);
      send_page(pc);
      send_page(pd);
      send_page(pc);
   endtask

   // random accesses drawn mostly from a small page pool so hits happen
   task automatic test_random_phase(input int cap, input int in_lim, input int out_lim,
                                    input int pool, input int count);
      logic [PB-1:0] hi, pg;
      set_policy(cap, in_lim, out_lim);
      hi = PB'({$urandom(), $urandom()});
      quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0)
            pg = PB'({$urandom(), $urandom()});
         else
            pg = {hi[PB-1:12], 12'($urandom_range(0, pool - 1))};
         send_page(pg);
         if (n == count / 2)
            quiet = !quiet;
      end
      quiet = 1'b0;
   endtask

   initial begin
      // reset policy
      cfg_capacity = CAPACITY_RESET;
      cfg_in_limit = IN_LIMIT_RESET;
      cfg_out_limit = OUT_LIMIT_RESET;
      main_cnt = 0;
      prob_cnt = 0;
      ghost_head = 0;
      ghost_cnt = 0;
      for (int i = 0; i < SLOTS; i++) begin
         res_valid[i] = 0;
         res_main[i] = 0;
         res_age[i] = 0;
      end
      for (int i = 0; i < HIST; i++)
         ghost_live[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_pages();
      test_random_phase(256, 64, 128, 300, 110);
      test_random_phase(1, 0, 1, 4, 90);
      test_random_phase(4, 1, 2, 10, 110);
      test_random_phase(8, 0, 255, 200, 240);   // fills history storage
      test_random_phase(16, 8, 3, 40, 110);
      test_random_phase(0, 255, 128, 3, 60);
      test_random_phase(511, 255, 1, 400, 90);
      test_random_phase($urandom_range(1, 64), $urandom_range(0, 32),
                        $urandom_range(1, 128), 80, 120);

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("** two_queue_page_tier_policy_unit: PASSED **");
      else
         $display("** two_queue_page_tier_policy_unit: FAILED **");
      $finish;
   end

endmodule

[two_queue_page_tier_policy_unit.f]
design/tqpt_pkg.sv
design/tqpt_slot_cell.sv
design/tqpt_hist_cell.sv
design/two_queue_page_tier_policy_unit.sv
tb/tb.sv
